// ----- rtl/tmfp_pkg.sv -----
// Shared types and constants for the message frame parser.
// No dependencies; tlv_message_frame_parser, tmfp_deframer and tmfp_checker use it.
package tmfp_pkg;

	localparam int unsigned FIXED_HDR  = 6;
	localparam int unsigned LEN_FIELD  = 2;
	localparam int unsigned WORD_BYTES = 4;

	typedef enum logic [3:0] {
		PH_TOTAL   = 4'd0,
		PH_HDRLEN  = 4'd1,
		PH_ID      = 4'd2,
		PH_FLAGS   = 4'd3,
		PH_CTYPE   = 4'd4,
		PH_OTYPE   = 4'd5,
		PH_OLEN    = 4'd6,
		PH_OVAL    = 4'd7,
		PH_PAYLOAD = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_CONTENT = 3'd1,
		ST_HDR_SHORT   = 3'd2,
		ST_OPT_OVERRUN = 3'd3,
		ST_TOTAL_SHORT = 3'd4
	} status_t;

	typedef struct packed {
		logic [3:0]  byte_kind;
		logic [7:0]  byte_value;
		logic [31:0] field_value;
		logic        field_complete;
		logic [7:0]  current_option_type;
		logic        end_of_message;
		logic [2:0]  status;
	} res_t;

	// first error in a frame wins
	function automatic status_t raise(input status_t cur, input status_t code);
		raise = (cur == ST_OK) ? code : cur;
	endfunction

endpackage

// ----- rtl/tmfp_in_if.sv -----
// Byte request channel of the message frame parser.
// Depends on nothing.
interface tmfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

// ----- rtl/tmfp_out_if.sv -----
// Result request channel of the message frame parser.
// Depends on nothing.
interface tmfp_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  byte_kind;
	logic [7:0]  byte_value;
	logic [31:0] field_value;
	logic        field_complete;
	logic [7:0]  current_option_type;
	logic        end_of_message;
	logic [2:0]  status;

	modport source (output valid, output byte_kind, output byte_value, output field_value,
		output field_complete, output current_option_type, output end_of_message,
		output status, input ready);
	modport sink (input valid, input byte_kind, input byte_value, input field_value,
		input field_complete, input current_option_type, input end_of_message,
		input status, output ready);
endinterface

// ----- rtl/tlv_message_frame_parser.sv -----
// Top level of the message frame parser: input stage, result stage, content-type register.
// Depends on tmfp_pkg, tmfp_in_if, tmfp_out_if and tmfp_deframer.
//
// Takes one stream byte per request and returns one classified result per byte, in order.
// Throughput is one byte per clock; an accepted byte passes the input register, then the
// result register, before its result is offered. The parse state updates as a byte moves
// from the input register into the result register, so bytes follow back to back with no
// bubbles; ready drops only when both stages hold data and the result side stalls.
// Write accepted_content_type only while no byte is in flight.
module tlv_message_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	tmfp_in_if.sink    stream,
	tmfp_out_if.source result,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            valid_s2;
	tmfp_pkg::res_t  res_s2;
	tmfp_pkg::res_t  res;
	logic [7:0]      ctype_q;
	logic            adv1;
	logic            adv2;

	assign adv2 = !valid_s2 || result.ready;
	assign adv1 = valid_s1 && adv2;
	assign stream.ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctype_q <= '0;
		else if (cfg_wr_en)
			ctype_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (stream.ready)
				valid_s1 <= stream.valid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready)
			byte_s1 <= stream.stream_byte;
		if (adv1)
			res_s2 <= res;
	end

	tmfp_deframer u_deframer (
		.clk                   (clk),
		.arst_n                (arst_n),
		.step                  (adv1),
		.data                  (byte_s1),
		.accepted_content_type (ctype_q),
		.res                   (res)
	);

	assign result.valid               = valid_s2;
	assign result.byte_kind           = res_s2.byte_kind;
	assign result.byte_value          = res_s2.byte_value;
	assign result.field_value         = res_s2.field_value;
	assign result.field_complete      = res_s2.field_complete;
	assign result.current_option_type = res_s2.current_option_type;
	assign result.end_of_message      = res_s2.end_of_message;
	assign result.status              = res_s2.status;

endmodule

// ----- rtl/tmfp_deframer.sv -----
// Frame parsing state and per-byte classification.
// Depends on tmfp_pkg; state advances on each step.
module tmfp_deframer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      data,
	input  logic [7:0]      accepted_content_type,
	output tmfp_pkg::res_t  res
);

	tmfp_pkg::phase_t  phase_q, phase_n;
	logic [1:0]        fbc_q, fbc_n;
	logic [31:0]       acc_q, acc_n;
	logic [31:0]       total_q, total_n;
	logic [15:0]       opt_left_q, opt_left_n;
	logic [7:0]        oval_left_q, oval_left_n;
	logic [7:0]        otype_q, otype_n;
	logic [31:0]       pay_left_q, pay_left_n;
	tmfp_pkg::status_t err_q, err_n;

	logic [31:0] acc_sh;
	logic [15:0] hlen;
	logic [16:0] need;
	logic [15:0] ob_dec;
	logic [7:0]  ov_dec;
	logic [31:0] pay_dec;
	logic [7:0]  oval_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= tmfp_pkg::PH_TOTAL;
			fbc_q       <= '0;
			acc_q       <= '0;
			total_q     <= '0;
			opt_left_q  <= '0;
			oval_left_q <= '0;
			otype_q     <= '0;
			pay_left_q  <= '0;
			err_q       <= tmfp_pkg::ST_OK;
		end else if (step) begin
			phase_q     <= phase_n;
			fbc_q       <= fbc_n;
			acc_q       <= acc_n;
			total_q     <= total_n;
			opt_left_q  <= opt_left_n;
			oval_left_q <= oval_left_n;
			otype_q     <= otype_n;
			pay_left_q  <= pay_left_n;
			err_q       <= err_n;
		end
	end

	assign acc_sh  = {((fbc_q == 2'd0) ? 24'd0 : acc_q[23:0]), data};
	assign hlen    = acc_sh[15:0];
	assign need    = {1'b0, hlen} + 17'(tmfp_pkg::LEN_FIELD);
	assign ob_dec  = opt_left_q - 16'd1;
	assign ov_dec  = oval_left_q - 8'd1;
	assign pay_dec = pay_left_q - 32'd1;
	assign oval_new = ({8'd0, data} > ob_dec) ? ob_dec[7:0] : data;

	always_comb begin
		phase_n     = phase_q;
		fbc_n       = fbc_q;
		acc_n       = acc_q;
		total_n     = total_q;
		opt_left_n  = opt_left_q;
		oval_left_n = oval_left_q;
		otype_n     = otype_q;
		pay_left_n  = pay_left_q;
		err_n       = err_q;

		res.byte_kind           = phase_q;
		res.byte_value          = data;
		res.field_value         = {24'd0, data};
		res.field_complete      = 1'b0;
		res.current_option_type = '0;
		res.end_of_message      = 1'b0;

		unique case (phase_q)
			tmfp_pkg::PH_HDRLEN: begin
				acc_n = acc_sh;
				res.field_value = acc_sh;
				if (fbc_q == 2'(tmfp_pkg::LEN_FIELD - 1)) begin
					res.field_complete = 1'b1;
					fbc_n = '0;
					if (hlen < 16'(tmfp_pkg::FIXED_HDR)) begin
						err_n = tmfp_pkg::raise(err_n, tmfp_pkg::ST_HDR_SHORT);
						opt_left_n = '0;
					end else begin
						opt_left_n = hlen - 16'(tmfp_pkg::FIXED_HDR);
					end
					if (total_q < {15'd0, need}) begin
						err_n = tmfp_pkg::raise(err_n, tmfp_pkg::ST_TOTAL_SHORT);
						pay_left_n = '0;
					end else begin
						pay_left_n = total_q - {15'd0, need};
					end
					phase_n = tmfp_pkg::PH_ID;
				end else begin
					fbc_n = fbc_q + 2'd1;
				end
			end
			tmfp_pkg::PH_ID: begin
				acc_n = acc_sh;
				res.field_value = acc_sh;
				if (fbc_q == 2'(tmfp_pkg::WORD_BYTES - 1)) begin
					res.field_complete = 1'b1;
					fbc_n = '0;
					phase_n = tmfp_pkg::PH_FLAGS;
				end else begin
					fbc_n = fbc_q + 2'd1;
				end
			end
			tmfp_pkg::PH_FLAGS: begin
				res.field_complete = 1'b1;
				phase_n = tmfp_pkg::PH_CTYPE;
			end
			tmfp_pkg::PH_CTYPE: begin
				res.field_complete = 1'b1;
				if (data != accepted_content_type)
					err_n = tmfp_pkg::raise(err_n, tmfp_pkg::ST_BAD_CONTENT);
				if (opt_left_q != '0) begin
					phase_n = tmfp_pkg::PH_OTYPE;
				end else if (pay_left_q != '0) begin
					phase_n = tmfp_pkg::PH_PAYLOAD;
				end else begin
					phase_n = tmfp_pkg::PH_TOTAL;
					res.end_of_message = 1'b1;
				end
			end
			tmfp_pkg::PH_OTYPE: begin
				otype_n = data;
				res.current_option_type = data;
				res.field_complete = 1'b1;
				opt_left_n = ob_dec;
				if (ob_dec == '0) begin
					err_n = tmfp_pkg::raise(err_n, tmfp_pkg::ST_OPT_OVERRUN);
					if (pay_left_q != '0) begin
						phase_n = tmfp_pkg::PH_PAYLOAD;
					end else begin
						phase_n = tmfp_pkg::PH_TOTAL;
						res.end_of_message = 1'b1;
					end
				end else begin
					phase_n = tmfp_pkg::PH_OLEN;
				end
			end
			tmfp_pkg::PH_OLEN: begin
				res.current_option_type = otype_q;
				res.field_complete = 1'b1;
				opt_left_n = ob_dec;
				if ({8'd0, data} > ob_dec)
					err_n = tmfp_pkg::raise(err_n, tmfp_pkg::ST_OPT_OVERRUN);
				oval_left_n = oval_new;
				fbc_n = '0;
				acc_n = '0;
				if (oval_new != '0) begin
					phase_n = tmfp_pkg::PH_OVAL;
				end else if (ob_dec != '0) begin
					phase_n = tmfp_pkg::PH_OTYPE;
				end else if (pay_left_q != '0) begin
					phase_n = tmfp_pkg::PH_PAYLOAD;
				end else begin
					phase_n = tmfp_pkg::PH_TOTAL;
					res.end_of_message = 1'b1;
				end
			end
			tmfp_pkg::PH_OVAL: begin
				res.current_option_type = otype_q;
				acc_n = {acc_q[23:0], data};
				res.field_value = {acc_q[23:0], data};
				oval_left_n = ov_dec;
				opt_left_n = ob_dec;
				if (ov_dec == '0) begin
					res.field_complete = 1'b1;
					if (ob_dec != '0) begin
						phase_n = tmfp_pkg::PH_OTYPE;
					end else if (pay_left_q != '0) begin
						phase_n = tmfp_pkg::PH_PAYLOAD;
					end else begin
						phase_n = tmfp_pkg::PH_TOTAL;
						res.end_of_message = 1'b1;
					end
				end
			end
			tmfp_pkg::PH_PAYLOAD: begin
				pay_left_n = pay_dec;
				if (pay_dec == '0) begin
					res.field_complete = 1'b1;
					res.end_of_message = 1'b1;
					phase_n = tmfp_pkg::PH_TOTAL;
				end
			end
			default: begin
				res.byte_kind = tmfp_pkg::PH_TOTAL;
				if (fbc_q == 2'd0)
					err_n = tmfp_pkg::ST_OK;
				acc_n = acc_sh;
				res.field_value = acc_sh;
				if (fbc_q == 2'(tmfp_pkg::WORD_BYTES - 1)) begin
					res.field_complete = 1'b1;
					total_n = acc_sh;
					fbc_n = '0;
					phase_n = tmfp_pkg::PH_HDRLEN;
				end else begin
					fbc_n = fbc_q + 2'd1;
					phase_n = tmfp_pkg::PH_TOTAL;
				end
			end
		endcase

		res.status = err_n;
	end

endmodule

// ----- rtl/tmfp_checker.sv -----
// Port-level checks for the message frame parser, bound to its top level.
// Depends on tmfp_pkg and the top-level ports of tlv_message_frame_parser.
module tmfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  byte_kind,
	input logic [7:0]  byte_value,
	input logic [31:0] field_value,
	input logic        field_complete,
	input logic [7:0]  current_option_type,
	input logic        end_of_message,
	input logic [2:0]  status
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(field_value)
			&& $stable(byte_kind) && $stable(status))
		else $error("result changed while stalled");

	a_eom_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_message |-> field_complete)
		else $error("end of message without field completion");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_kind <= 4'(tmfp_pkg::PH_PAYLOAD))
		else $error("byte kind out of range");

	a_otype: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(byte_kind == 4'(tmfp_pkg::PH_OTYPE) || byte_kind == 4'(tmfp_pkg::PH_OLEN)
			|| byte_kind == 4'(tmfp_pkg::PH_OVAL)) |-> current_option_type == 8'd0)
		else $error("option type outside options");

endmodule

bind tlv_message_frame_parser tmfp_checker u_tmfp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (result.valid),
	.out_ready           (result.ready),
	.byte_kind           (result.byte_kind),
	.byte_value          (result.byte_value),
	.field_value         (result.field_value),
	.field_complete      (result.field_complete),
	.current_option_type (result.current_option_type),
	.end_of_message      (result.end_of_message),
	.status              (result.status)
);

// ----- sim/testbench.sv -----
// Self-checking bench for tlv_message_frame_parser: random and directed frames in, one result per byte.
// Holds its own byte-level parser to predict every result; uses tmfp_pkg, tmfp_in_if, tmfp_out_if.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_BYTES  = 100;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	tmfp_in_if  in_ch();
	tmfp_out_if out_ch();

	tlv_message_frame_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (in_ch),
		.result     (out_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// parser shadow state
	tmfp_pkg::phase_t  p_phase;
	logic [1:0]        p_cnt;
	logic [31:0]       p_acc;
	logic [31:0]       p_total;
	logic [15:0]       p_opt_left;
	logic [7:0]        p_val_left;
	logic [7:0]        p_opt_type;
	logic [31:0]       p_pay_left;
	tmfp_pkg::status_t p_err;
	logic [7:0]        p_ctype;

	logic [7:0]      stream_q[$];
	logic [7:0]      frame_q[$];
	logic [7:0]      opt_buf[$];
	tmfp_pkg::res_t  result_exp_q[$];

	bit          tx_idle;
	bit          rx_idle;
	int unsigned tx_hold;
	int unsigned rx_hold;
	int unsigned rx_wait;
	int unsigned cycle_cnt;
	int unsigned bytes_sent;
	int unsigned results_seen;
	int unsigned frames_done;
	int unsigned frames_flagged;
	int unsigned fail_cnt;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [31:0] shift_word(input logic [7:0] b);
		return (p_cnt == 2'd0) ? {24'd0, b} : {p_acc[23:0], b};
	endfunction

	function automatic void flag_fault(input tmfp_pkg::status_t code);
		if (p_err == tmfp_pkg::ST_OK)
			p_err = code;
	endfunction

	function automatic bit leave_header();
		if (p_pay_left != 0) begin
			p_phase = tmfp_pkg::PH_PAYLOAD;
			return 1'b0;
		end
		p_phase = tmfp_pkg::PH_TOTAL;
		return 1'b1;
	endfunction

	function automatic bit close_option();
		if (p_opt_left != 0) begin
			p_phase = tmfp_pkg::PH_OTYPE;
			return 1'b0;
		end
		return leave_header();
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		tmfp_pkg::res_t r;
		logic [15:0]    h;
		r = '0;
		r.byte_kind = p_phase;
		r.byte_value = b;
		r.field_value = {24'd0, b};
		case (p_phase)
			tmfp_pkg::PH_HDRLEN: begin
				p_acc = shift_word(b);
				r.field_value = p_acc;
				if (p_cnt == tmfp_pkg::LEN_FIELD - 1) begin
					r.field_complete = 1'b1;
					p_cnt = 2'd0;
					h = p_acc[15:0];
					if (h < tmfp_pkg::FIXED_HDR) begin
						flag_fault(tmfp_pkg::ST_HDR_SHORT);
						p_opt_left = '0;
					end else begin
						p_opt_left = h - 16'(tmfp_pkg::FIXED_HDR);
					end
					if (p_total < {16'd0, h} + 32'(tmfp_pkg::LEN_FIELD)) begin
						flag_fault(tmfp_pkg::ST_TOTAL_SHORT);
						p_pay_left = '0;
					end else begin
						p_pay_left = p_total - {16'd0, h} - 32'(tmfp_pkg::LEN_FIELD);
					end
					p_phase = tmfp_pkg::PH_ID;
				end else begin
					p_cnt = p_cnt + 2'd1;
				end
			end
			tmfp_pkg::PH_ID: begin
				p_acc = shift_word(b);
				r.field_value = p_acc;
				if (p_cnt == tmfp_pkg::WORD_BYTES - 1) begin
					r.field_complete = 1'b1;
					p_cnt = 2'd0;
					p_phase = tmfp_pkg::PH_FLAGS;
				end else begin
					p_cnt = p_cnt + 2'd1;
				end
			end
			tmfp_pkg::PH_FLAGS: begin
				r.field_complete = 1'b1;
				p_phase = tmfp_pkg::PH_CTYPE;
			end
			tmfp_pkg::PH_CTYPE: begin
				r.field_complete = 1'b1;
				if (b != p_ctype)
					flag_fault(tmfp_pkg::ST_BAD_CONTENT);
				if (p_opt_left != 0)
					p_phase = tmfp_pkg::PH_OTYPE;
				else
					r.end_of_message = leave_header();
			end
			tmfp_pkg::PH_OTYPE: begin
				p_opt_type = b;
				r.current_option_type = b;
				r.field_complete = 1'b1;
				p_opt_left = p_opt_left - 16'd1;
				if (p_opt_left == 0) begin
					flag_fault(tmfp_pkg::ST_OPT_OVERRUN);
					r.end_of_message = leave_header();
				end else begin
					p_phase = tmfp_pkg::PH_OLEN;
				end
			end
			tmfp_pkg::PH_OLEN: begin
				r.current_option_type = p_opt_type;
				r.field_complete = 1'b1;
				p_opt_left = p_opt_left - 16'd1;
				if ({8'd0, b} > p_opt_left) begin
					flag_fault(tmfp_pkg::ST_OPT_OVERRUN);
					p_val_left = p_opt_left[7:0];
				end else begin
					p_val_left = b;
				end
				p_cnt = 2'd0;
				p_acc = '0;
				if (p_val_left == 0)
					r.end_of_message = close_option();
				else
					p_phase = tmfp_pkg::PH_OVAL;
			end
			tmfp_pkg::PH_OVAL: begin
				r.current_option_type = p_opt_type;
				p_acc = {p_acc[23:0], b};
				r.field_value = p_acc;
				p_val_left = p_val_left - 8'd1;
				p_opt_left = p_opt_left - 16'd1;
				if (p_val_left == 0) begin
					r.field_complete = 1'b1;
					r.end_of_message = close_option();
				end
			end
			tmfp_pkg::PH_PAYLOAD: begin
				p_pay_left = p_pay_left - 32'd1;
				if (p_pay_left == 0) begin
					r.field_complete = 1'b1;
					r.end_of_message = 1'b1;
					p_phase = tmfp_pkg::PH_TOTAL;
				end
			end
			default: begin
				r.byte_kind = tmfp_pkg::PH_TOTAL;
				if (p_cnt == 2'd0)
					p_err = tmfp_pkg::ST_OK;
				p_acc = shift_word(b);
				r.field_value = p_acc;
				if (p_cnt == tmfp_pkg::WORD_BYTES - 1) begin
					r.field_complete = 1'b1;
					p_total = p_acc;
					p_cnt = 2'd0;
					p_phase = tmfp_pkg::PH_HDRLEN;
				end else begin
					p_cnt = p_cnt + 2'd1;
					p_phase = tmfp_pkg::PH_TOTAL;
				end
			end
		endcase
		r.status = p_err;
		if (r.end_of_message) begin
			frames_done++;
			if (p_err != tmfp_pkg::ST_OK)
				frames_flagged++;
		end
		result_exp_q.push_back(r);
	endtask

	task automatic match_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic check_result();
		tmfp_pkg::res_t e;
		results_seen++;
		if (result_exp_q.size() == 0) begin
			$error("result with no request pending: byte_value %h", out_ch.byte_value);
			fail_cnt++;
		end else begin
			e = result_exp_q.pop_front();
			match_field("byte_kind", e.byte_kind, out_ch.byte_kind);
			match_field("byte_value", e.byte_value, out_ch.byte_value);
			match_field("field_value", e.field_value, out_ch.field_value);
			match_field("field_complete", e.field_complete, out_ch.field_complete);
			match_field("current_option_type", e.current_option_type,
				out_ch.current_option_type);
			match_field("end_of_message", e.end_of_message, out_ch.end_of_message);
			match_field("status", e.status, out_ch.status);
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.stream_byte <= '0;
			tx_hold <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				parse_byte(in_ch.stream_byte);
				bytes_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (tx_hold != 0) begin
					in_ch.valid <= 1'b0;
					tx_hold <= tx_hold - 1;
				end else if (stream_q.size() != 0) begin
					in_ch.valid <= 1'b1;
					in_ch.stream_byte <= stream_q.pop_front();
					tx_hold <= tx_idle ? $urandom_range(0, 15) : 0;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_hold <= 0;
		end else begin
			rx_wait = rx_hold;
			if (out_ch.valid && out_ch.ready) begin
				check_result();
				rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
			end
			if (rx_wait != 0) begin
				out_ch.ready <= 1'b0;
				rx_hold <= rx_wait - 1;
			end else begin
				out_ch.ready <= 1'b1;
				rx_hold <= 0;
			end
		end
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (stream_q.size() != 0 || in_ch.valid || result_exp_q.size() != 0);
	endtask

	task automatic write_ctype(input logic [7:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		p_ctype = v;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic fill_clean_options(input int n);
		int left;
		int top;
		int len;
		opt_buf.delete();
		left = n;
		while (left > 0) begin
			top = left - 2;
			if (top > 12)
				top = 12;
			len = $urandom_range(0, top);
			if (left - 2 - len == 1)
				len++;
			opt_buf.push_back(8'($urandom));
			opt_buf.push_back(8'(len));
			repeat (len) opt_buf.push_back(8'($urandom));
			left -= 2 + len;
		end
	endtask

	// frame bytes go to frame_q; the option area comes from opt_buf
	task automatic emit_frame(input logic [15:0] hdr, input logic [31:0] total,
		input logic [7:0] ctype);
		logic [31:0] id;
		int unsigned pay;
		id = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		pay = (total >= {16'd0, hdr} + 32'd2) ? total - {16'd0, hdr} - 32'd2 : 0;
		for (int i = 3; i >= 0; i--)
			frame_q.push_back(total[8*i +: 8]);
		frame_q.push_back(hdr[15:8]);
		frame_q.push_back(hdr[7:0]);
		for (int i = 3; i >= 0; i--)
			frame_q.push_back(id[8*i +: 8]);
		frame_q.push_back(pick_byte());
		frame_q.push_back(ctype);
		foreach (opt_buf[i])
			frame_q.push_back(opt_buf[i]);
		repeat (pay) frame_q.push_back(pick_byte());
		opt_buf.delete();
	endtask

	task automatic add_random_frame();
		int          nopt;
		int unsigned pay;
		logic [15:0] hdr;
		logic [31:0] total;
		logic [7:0]  ct;
		nopt = $urandom_range(0, 20);
		if (nopt == 1)
			nopt = 0;
		pay = $urandom_range(0, 12);
		ct = ($urandom_range(0, 7) == 0) ? 8'($urandom) : p_ctype;
		fill_clean_options(nopt);
		hdr = 16'(6 + nopt);
		total = 32'(hdr) + 32'd2 + pay;
		case ($urandom_range(0, 9))
			6: begin
				opt_buf.delete();
				hdr = 16'($urandom_range(0, 5));
				total = $urandom_range(0, 16);
			end
			7: total = $urandom_range(0, 32'(hdr) + 1);
			8: begin
				opt_buf.delete();
				nopt = $urandom_range(1, 20);
				repeat (nopt) opt_buf.push_back(8'($urandom));
				hdr = 16'(6 + nopt);
				total = 32'(hdr) + 32'd2 + pay;
			end
			9: ct = p_ctype ^ 8'($urandom_range(1, 255));
			default: ;
		endcase
		emit_frame(hdr, total, ct);
	endtask

	// hand the staged bytes over, stopping once mid-stream until all results are back
	task automatic release_frames();
		int unsigned cut;
		cut = $urandom_range(1, frame_q.size() - 1);
		repeat (cut) stream_q.push_back(frame_q.pop_front());
		wait_drained();
		while (frame_q.size() != 0)
			stream_q.push_back(frame_q.pop_front());
	endtask

	initial begin
		logic [7:0] plan_ctype;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.stream_byte = '0;
		out_ch.ready = 1'b0;
		p_phase = tmfp_pkg::PH_TOTAL;
		p_cnt = '0;
		p_acc = '0;
		p_total = '0;
		p_opt_left = '0;
		p_val_left = '0;
		p_opt_type = '0;
		p_pay_left = '0;
		p_err = tmfp_pkg::ST_OK;
		p_ctype = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no options, no payload: ends on the content type
		emit_frame(16'd6, 32'd8, 8'h00);
		// content type rejected, one payload byte
		emit_frame(16'd6, 32'd9, 8'h5a);
		// header and total both short, header error kept
		emit_frame(16'd0, 32'd0, 8'h00);
		emit_frame(16'd4, 32'd10, 8'h00);
		// total short with options present
		fill_clean_options(4);
		emit_frame(16'd10, 32'd5, 8'h00);
		// option type on the last option byte
		opt_buf = {8'hc3};
		emit_frame(16'd7, 32'd11, 8'h00);
		// option length past the option area
		opt_buf = {8'h11, 8'hff, 8'hde, 8'had, 8'hbe};
		emit_frame(16'd11, 32'd14, 8'h00);
		// zero-length option closing the frame
		opt_buf = {8'h80, 8'h00};
		emit_frame(16'd8, 32'd10, 8'h00);
		// value wider than 32 bits
		opt_buf = {8'h42, 8'h08, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef};
		emit_frame(16'd16, 32'd20, 8'hff);
		release_frames();

		for (int ph = 1; ph <= 4; ph++) begin
			case (ph)
				1: plan_ctype = 8'hff;
				3: plan_ctype = 8'h00;
				default: plan_ctype = 8'($urandom);
			endcase
			write_ctype(plan_ctype);
			tx_idle = (ph != 1) && (ph != 3);
			rx_idle = (ph != 1) && (ph != 2);
			if (ph == 1) begin
				// option area above 255 bytes, longest option value
				opt_buf.push_back(8'h7e);
				opt_buf.push_back(8'hff);
				repeat (255) opt_buf.push_back(8'($urandom));
				opt_buf.push_back(8'h01);
				opt_buf.push_back(8'h01);
				opt_buf.push_back(8'h5c);
				emit_frame(16'd266, 32'd271, p_ctype);
			end
			while (frame_q.size() < PHASE_BYTES)
				add_random_frame();
			release_frames();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (result_exp_q.size() != 0) begin
			$error("%0d results never arrived", result_exp_q.size());
			fail_cnt++;
		end
		$display("Sent %0d bytes over %0d frames, %0d of them with a status raised.",
			bytes_sent, frames_done, frames_flagged);
		$display("Checked %0d results across five content type settings.", results_seen);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
